[rtl/cau_pkg.sv]
// Package for the complex arithmetic unit: operation and status codes,
// datapath widths and the structs passed between the front end and the top.
// No dependencies.
package cau_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DW  = 32;          // port data width
   localparam int OPW = DW + 1;      // multiplier operand width
   localparam int PW  = 2 * OPW;     // product width
   localparam int SW  = PW + 1;      // sum of two products
   localparam int MW  = 64;          // dividend magnitude and divisor width
   localparam int QB  = DW + 1;      // quotient bits before rounding
   localparam int RW  = MW + QB + 1; // partial remainder, holds mag << frac

   localparam logic [4:0] OP_ADD    = 5'd0;
   localparam logic [4:0] OP_SUB    = 5'd1;
   localparam logic [4:0] OP_MUL    = 5'd2;
   localparam logic [4:0] OP_DIV    = 5'd3;
   localparam logic [4:0] OP_CONJ   = 5'd4;
   localparam logic [4:0] OP_NEG    = 5'd5;
   localparam logic [4:0] OP_ADDI   = 5'd6;
   localparam logic [4:0] OP_SUBI   = 5'd7;
   localparam logic [4:0] OP_ADDC   = 5'd8;
   localparam logic [4:0] OP_SUBC   = 5'd9;
   localparam logic [4:0] OP_DADD   = 5'd10;
   localparam logic [4:0] OP_DSUB   = 5'd11;
   localparam logic [4:0] OP_DADDI  = 5'd12;
   localparam logic [4:0] OP_DSUBI  = 5'd13;
   localparam logic [4:0] OP_DADDC  = 5'd14;
   localparam logic [4:0] OP_DSUBC  = 5'd15;
   localparam logic [4:0] OP_IDADD  = 5'd16;
   localparam logic [4:0] OP_IDSUB  = 5'd17;
   localparam logic [4:0] OP_IDADDC = 5'd18;
   localparam logic [4:0] OP_IDSUBC = 5'd19;
   localparam logic [4:0] OP_SCALE  = 5'd20;
   localparam logic [4:0] OP_NORM   = 5'd21;
   localparam logic [4:0] OP_INV    = 5'd22;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_SAT = 2'd1;
   localparam logic [1:0] ST_DZ  = 2'd2;

   typedef struct packed {
      logic                 valid;
      logic                 is_div;
      logic                 dz;
      logic signed [SW-1:0] re;
      logic signed [SW-1:0] im;
      logic                 re_neg;
      logic                 im_neg;
      logic [MW-1:0]        re_mag;
      logic [MW-1:0]        im_mag;
      logic [MW-1:0]        den;
   } front_out_type;

   typedef struct packed {
      logic                 is_div;
      logic                 dz;
      logic signed [SW-1:0] re;
      logic signed [SW-1:0] im;
   } side_type;

endpackage

[rtl/cau_front.sv]
// Front end: operand decode, six multipliers, rounding and sums.
// Five register stages. Depends on cau_pkg.
module cau_front #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [4:0]            in_op,
   input  logic signed [31:0]    in_a_re,
   input  logic signed [31:0]    in_a_im,
   input  logic signed [31:0]    in_b_re,
   input  logic signed [31:0]    in_b_im,
   input  logic signed [31:0]    in_d,
   output cau_pkg::front_out_type out
);
   import cau_pkg::*;

   localparam logic signed [OPW-1:0] ONE  = OPW'(64'd1 << FRAC_BITS);
   localparam logic [PW-1:0]         HALF = PW'(64'd1 << (FRAC_BITS - 1));

   function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p);
      logic [PW-1:0] m;
      logic [PW-1:0] q;
      m = p[PW-1] ? (~p + PW'(1)) : p;
      q = (m + HALF) >> FRAC_BITS;
      rnd = p[PW-1] ? -$signed(q) : $signed(q);
   endfunction

   // stage 0
   logic                 v0_ff;
   logic [4:0]           op0_ff;
   logic signed [31:0]   ar0_ff, ai0_ff, br0_ff, bi0_ff, d0_ff;
   // stage 1
   logic                 v1_ff, div1_ff;
   logic signed [OPW-1:0] mx_in [0:5];
   logic signed [OPW-1:0] my_in [0:5];
   logic signed [OPW-1:0] mx_ff [0:5];
   logic signed [OPW-1:0] my_ff [0:5];
   logic                 div_in;
   // stage 2
   logic                 v2_ff, div2_ff;
   logic signed [PW-1:0] p_ff [0:5];
   // stage 3
   logic                 v3_ff, div3_ff;
   logic signed [PW-1:0] r_ff [0:3];
   logic signed [SW-1:0] nre_ff, nim_ff;
   logic [MW-1:0]        den3_ff;
   // stage 4
   front_out_type        out_ff;
   logic signed [SW-1:0] ar, ai, br, bi, dd, pr, pi, nr, ni, vr, vi;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_comb begin
      ar = SW'(ar0_ff);
      ai = SW'(ai0_ff);
      br = SW'(br0_ff);
      bi = SW'(bi0_ff);
      dd = SW'(d0_ff);
      case (op0_ff)
         OP_ADD, OP_DADD, OP_IDADD: begin
            pr = ar + br; pi = ai + bi;
         end
         OP_SUB, OP_DSUB, OP_IDSUB: begin
            pr = ar - br; pi = ai - bi;
         end
         OP_ADDI, OP_DADDI: begin
            pr = ar - bi; pi = ai + br;
         end
         OP_SUBI, OP_DSUBI: begin
            pr = ar + bi; pi = ai - br;
         end
         OP_ADDC, OP_DADDC, OP_IDADDC: begin
            pr = ar + br; pi = ai - bi;
         end
         OP_SUBC, OP_DSUBC, OP_IDSUBC: begin
            pr = ar - br; pi = ai + bi;
         end
         OP_CONJ: begin
            pr = ar; pi = -ai;
         end
         OP_NEG: begin
            pr = -ar; pi = -ai;
         end
         default: begin
            pr = '0; pi = '0;
         end
      endcase
      div_in = (op0_ff == OP_DIV) || (op0_ff == OP_INV);
      nr = (op0_ff == OP_DIV) ? ar : SW'(ONE);
      ni = (op0_ff == OP_DIV) ? ai : '0;
      vr = (op0_ff == OP_DIV) ? br : ar;
      vi = (op0_ff == OP_DIV) ? bi : ai;
      for (int i = 0; i < 6; i++) begin
         mx_in[i] = '0;
         my_in[i] = '0;
      end
      case (op0_ff)
         OP_ADD, OP_SUB, OP_ADDI, OP_SUBI, OP_ADDC, OP_SUBC, OP_CONJ, OP_NEG: begin
            mx_in[0] = OPW'(pr); my_in[0] = ONE;
            mx_in[2] = OPW'(pi); my_in[2] = ONE;
         end
         OP_DADD, OP_DSUB, OP_DADDI, OP_DSUBI, OP_DADDC, OP_DSUBC: begin
            mx_in[0] = OPW'(dd); my_in[0] = OPW'(pr);
            mx_in[2] = OPW'(dd); my_in[2] = OPW'(pi);
         end
         OP_IDADD, OP_IDSUB, OP_IDADDC, OP_IDSUBC: begin
            mx_in[0] = OPW'(-dd); my_in[0] = OPW'(pi);
            mx_in[2] = OPW'(dd);  my_in[2] = OPW'(pr);
         end
         OP_MUL: begin
            mx_in[0] = OPW'(ar); my_in[0] = OPW'(br);
            mx_in[1] = OPW'(ai); my_in[1] = OPW'(-bi);
            mx_in[2] = OPW'(ai); my_in[2] = OPW'(br);
            mx_in[3] = OPW'(ar); my_in[3] = OPW'(bi);
         end
         OP_SCALE: begin
            mx_in[0] = OPW'(dd); my_in[0] = OPW'(ar);
            mx_in[2] = OPW'(dd); my_in[2] = OPW'(ai);
         end
         OP_NORM: begin
            mx_in[0] = OPW'(ar); my_in[0] = OPW'(ar);
            mx_in[1] = OPW'(ai); my_in[1] = OPW'(ai);
         end
         OP_DIV, OP_INV: begin
            mx_in[0] = OPW'(nr);  my_in[0] = OPW'(vr);
            mx_in[1] = OPW'(ni);  my_in[1] = OPW'(vi);
            mx_in[2] = OPW'(ni);  my_in[2] = OPW'(vr);
            mx_in[3] = OPW'(-nr); my_in[3] = OPW'(vi);
            mx_in[4] = OPW'(vr);  my_in[4] = OPW'(vr);
            mx_in[5] = OPW'(vi);  my_in[5] = OPW'(vi);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op0_ff <= in_op;
      ar0_ff <= in_a_re;
      ai0_ff <= in_a_im;
      br0_ff <= in_b_re;
      bi0_ff <= in_b_im;
      d0_ff  <= in_d;

      div1_ff <= div_in;
      for (int i = 0; i < 6; i++) begin
         mx_ff[i] <= mx_in[i];
         my_ff[i] <= my_in[i];
      end

      div2_ff <= div1_ff;
      for (int i = 0; i < 6; i++) begin
         p_ff[i] <= mx_ff[i] * my_ff[i];
      end

      div3_ff <= div2_ff;
      for (int i = 0; i < 4; i++) begin
         r_ff[i] <= rnd(p_ff[i]);
      end
      nre_ff  <= SW'(p_ff[0]) + SW'(p_ff[1]);
      nim_ff  <= SW'(p_ff[2]) + SW'(p_ff[3]);
      den3_ff <= MW'(p_ff[4]) + MW'(p_ff[5]);

      out_ff.is_div <= div3_ff;
      out_ff.dz     <= (den3_ff == '0);
      out_ff.re     <= SW'(r_ff[0]) + SW'(r_ff[1]);
      out_ff.im     <= SW'(r_ff[2]) + SW'(r_ff[3]);
      out_ff.re_neg <= nre_ff[SW-1];
      out_ff.im_neg <= nim_ff[SW-1];
      out_ff.re_mag <= MW'(nre_ff[SW-1] ? -nre_ff : nre_ff);
      out_ff.im_mag <= MW'(nim_ff[SW-1] ? -nim_ff : nim_ff);
      out_ff.den    <= den3_ff;
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= v3_ff;
      end
   end

   assign out = out_ff;

endmodule

[rtl/cau_div_lane.sv]
// One divider lane: rounded quotient of (mag << frac) / den, restoring,
// one quotient bit per stage, plus an overflow precheck. Depends on cau_pkg.
module cau_div_lane #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   in_neg,
   input  logic [cau_pkg::MW-1:0] in_mag,
   input  logic [cau_pkg::MW-1:0] in_den,
   output logic [cau_pkg::QB:0]   out_q,
   output logic                   out_neg,
   output logic                   out_ovf
);
   import cau_pkg::*;

   logic [RW-1:0] r_ff [0:QB];
   logic [MW-1:0] d_ff [0:QB];
   logic [QB-1:0] q_ff [0:QB];
   logic          n_ff [0:QB];
   logic          o_ff [0:QB];
   logic [RW-1:0] dsh  [0:QB-1];
   logic          ge   [0:QB-1];
   logic [RW-1:0] num0;
   logic          inc;
   logic [QB:0]   qo_ff;
   logic          no_ff, oo_ff;

   assign num0 = RW'(in_mag) << FRAC_BITS;

   always_comb begin
      for (int j = 0; j < QB; j++) begin
         dsh[j] = RW'(d_ff[j]) << (QB - 1 - j);
         ge[j]  = (r_ff[j] >= dsh[j]);
      end
      inc = ({r_ff[QB][MW-1:0], 1'b0} >= {1'b0, d_ff[QB]});
   end

   always_ff @(posedge clock) begin
      r_ff[0] <= num0;
      d_ff[0] <= in_den;
      q_ff[0] <= '0;
      n_ff[0] <= in_neg;
      o_ff[0] <= (num0 >= (RW'(in_den) << QB));
      for (int j = 0; j < QB; j++) begin
         r_ff[j+1] <= ge[j] ? (r_ff[j] - dsh[j]) : r_ff[j];
         q_ff[j+1] <= {q_ff[j][QB-2:0], ge[j]};
         d_ff[j+1] <= d_ff[j];
         n_ff[j+1] <= n_ff[j];
         o_ff[j+1] <= o_ff[j];
      end
      qo_ff <= (QB+1)'(q_ff[QB]) + (QB+1)'(inc);
      no_ff <= n_ff[QB];
      oo_ff <= o_ff[QB];
   end

   assign out_q   = qo_ff;
   assign out_neg = no_ff;
   assign out_ovf = oo_ff;

endmodule

[rtl/complex_arith_unit.sv]
// Complex arithmetic unit, top level: front end, two divider lanes and the
// saturating output stage. Depends on cau_pkg, cau_front, cau_div_lane.
//
// Usage: drive req_* and raise start; the request transfers on any rising
// edge with start high and busy low. busy stays low, so one request may
// transfer every cycle. Each request gives exactly one result, shown on
// rsp_* with rsp_valid high for one cycle, in request order.
// Every operation passes through the same stages: 5 front-end stages
// (operand decode, multipliers, rounding, sums), 35 divider-lane stages
// (precheck, 33 quotient bits at one bit per stage, rounding) and the
// output register. Throughput is one result per cycle; the quotient
// chain sets the latency. Non-divide results ride alongside the lanes.
// Reset (synchronous, active high) clears every valid bit; requests in
// flight are dropped and no result follows them. The receiver cannot
// stall, so no back-pressure exists inside the pipeline.
module complex_arith_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [4:0]         req_type,
   input  logic signed [31:0] req_a_re,
   input  logic signed [31:0] req_a_im,
   input  logic signed [31:0] req_b_re,
   input  logic signed [31:0] req_b_im,
   input  logic signed [31:0] req_scale_d,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_res_re,
   output logic signed [31:0] rsp_res_im,
   output logic [1:0]         rsp_status
);
   import cau_pkg::*;

   localparam int LANE_LAT = QB + 2;
   localparam int LAT      = 5 + LANE_LAT + 1;
   localparam logic [QB:0] LIM_POS = (QB+1)'(64'h7FFF_FFFF);
   localparam logic [QB:0] LIM_NEG = (QB+1)'(64'h8000_0000);

   function automatic logic [DW:0] sat(input logic signed [SW-1:0] v);
      if (v > SW'(64'sh7FFF_FFFF)) begin
         sat = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -SW'(64'sh8000_0000)) begin
         sat = {1'b1, 32'h8000_0000};
      end else begin
         sat = {1'b0, v[DW-1:0]};
      end
   endfunction

   function automatic logic [DW:0] dsat(input logic [QB:0] q, input logic neg,
                                        input logic ovf);
      logic [QB:0] nq;
      nq = -q;
      if (ovf || (q > (neg ? LIM_NEG : LIM_POS))) begin
         dsat = neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
      end else begin
         dsat = {1'b0, neg ? nq[DW-1:0] : q[DW-1:0]};
      end
   endfunction

   front_out_type    fo;
   logic [QB:0]      qre, qim;
   logic             nre, nim, ore, oim;
   logic             sv_ff [0:LANE_LAT-1];
   side_type         sd_ff [0:LANE_LAT-1];
   side_type         sd;
   logic [DW:0]      xre, xim;
   logic             valid_ff;
   logic signed [31:0] re_ff, im_ff;
   logic [1:0]       st_ff, st_in;
   logic signed [31:0] re_in, im_in;

   assign busy = 1'b0;

   cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_op    (req_type),
      .in_a_re  (req_a_re),
      .in_a_im  (req_a_im),
      .in_b_re  (req_b_re),
      .in_b_im  (req_b_im),
      .in_d     (req_scale_d),
      .out      (fo)
   );

   cau_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_re (
      .clock   (clock),
      .in_neg  (fo.re_neg),
      .in_mag  (fo.re_mag),
      .in_den  (fo.den),
      .out_q   (qre),
      .out_neg (nre),
      .out_ovf (ore)
   );

   cau_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_im (
      .clock   (clock),
      .in_neg  (fo.im_neg),
      .in_mag  (fo.im_mag),
      .in_den  (fo.den),
      .out_q   (qim),
      .out_neg (nim),
      .out_ovf (oim)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) begin
            sv_ff[i] <= 1'b0;
         end
         valid_ff <= 1'b0;
      end else begin
         sv_ff[0] <= fo.valid;
         for (int i = 1; i < LANE_LAT; i++) begin
            sv_ff[i] <= sv_ff[i-1];
         end
         valid_ff <= sv_ff[LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      sd_ff[0] <= '{is_div: fo.is_div, dz: fo.dz, re: fo.re, im: fo.im};
      for (int i = 1; i < LANE_LAT; i++) begin
         sd_ff[i] <= sd_ff[i-1];
      end
      re_ff <= re_in;
      im_ff <= im_in;
      st_ff <= st_in;
   end

   assign sd = sd_ff[LANE_LAT-1];

   always_comb begin
      if (sd.is_div) begin
         xre = dsat(qre, nre, ore);
         xim = dsat(qim, nim, oim);
      end else begin
         xre = sat(sd.re);
         xim = sat(sd.im);
      end
      if (sd.is_div && sd.dz) begin
         re_in = '0;
         im_in = '0;
         st_in = ST_DZ;
      end else begin
         re_in = $signed(xre[DW-1:0]);
         im_in = $signed(xim[DW-1:0]);
         st_in = (xre[DW] || xim[DW]) ? ST_SAT : ST_OK;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_res_re = re_ff;
   assign rsp_res_im = im_ff;
   assign rsp_status = st_ff;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without a matching request");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DZ) |-> (rsp_res_re == '0 && rsp_res_im == '0))
      else $error("division by zero result not zero");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_SAT || rsp_status == ST_DZ))
      else $error("undefined status code");
`endif

endmodule
